@@ rtl/blr_pkg.sv @@
package blr_pkg;

  // Screen defaults
  localparam int DEF_SCREEN_WIDTH  = 480;
  localparam int DEF_SCREEN_HEIGHT = 320;

  // Field widths
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 18;
  localparam int ERR_W   = 18;

  // Transaction modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] pen_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               visible;
    logic               last;
  } out_item_t;

  // Classified command, with the line set-up already worked out for loads
  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] delta_x;
    logic [COORD_W-1:0] delta_y;
    logic               dir_x_neg;
    logic               dir_y_neg;
    logic [ERR_W-1:0]   error_term;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic active;
    logic pop;
    logic head_tick;
  } back_stat_t;

endpackage

@@ rtl/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer with screen clipping.
// Input channel (in_valid/in_ready/in_data): mode 0 loads a line (two
// endpoints and a colour) and returns nothing; mode 1 is a tick that returns
// the next point of the active line, or nothing when no line is active.
// A load arriving mid-line replaces that line.
// Result channel (out_valid/out_ready/out_data): one point per productive
// tick, with its frame word address (zero when off screen), the colour,
// the visible flag and the last flag on the end point.
// Latency: a tick's point passes through the command queue and then the
// output register before it appears on the result channel.
// Throughput: one transaction per cycle while in_ready is high, set by
// the back-end stepper's error step and one-pixel-per-clock output register.
// A two-entry queue decouples the input from the stepper, so the input keeps
// taking transactions while a finished point waits on the output.
// Reset (rst_n, synchronous, active low) empties the queue, drops any
// pending point and leaves the rasterizer idle.
// When the receiver stalls, the point holds; ticks for the active line wait
// in the queue, and in_ready drops once it holds two entries.
module bresenham_line_rasterizer #(
  parameter int SCREEN_WIDTH  = blr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = blr_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  blr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output blr_pkg::out_item_t  out_data
);

  blr_pkg::cmd_t        front_cmd;
  blr_pkg::cmd_t        head_cmd;
  blr_pkg::q_status_t   q_stat;
  blr_pkg::back_stat_t  b_stat;
  logic                 push;
  logic                 pop;

  // Classify incoming transactions
  blr_front u_front (
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Queue commands between front and stepper
  blr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_cmd),
    .pop     (pop),
    .rd_data (head_cmd),
    .stat    (q_stat)
  );

  // Step lines and emit points
  blr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .head      (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (b_stat)
  );

  // Queue status must be consistent
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  // A tick on an active line must not be popped while the point is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_stat.pop && b_stat.head_tick && b_stat.active && out_valid && !out_ready))
    else $error("tick popped over a stalled point");

  // A new point only comes from an active line
  a_point_from_active: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(b_stat.active))
    else $error("point emitted with no active line");

endmodule

@@ rtl/blr_front.sv @@
module blr_front (
  input  blr_pkg::in_item_t in_data,
  output blr_pkg::cmd_t     cmd
);

  // Classify the transaction and set up the line parameters for a load
  always_comb begin
    cmd.is_load   = (in_data.mode == blr_pkg::MODE_LOAD);
    cmd.start_x   = in_data.start_x;
    cmd.start_y   = in_data.start_y;
    cmd.end_x     = in_data.end_x;
    cmd.end_y     = in_data.end_y;
    cmd.color     = in_data.pen_color;
    cmd.dir_x_neg = !(in_data.start_x < in_data.end_x);
    cmd.dir_y_neg = !(in_data.start_y < in_data.end_y);
    if (in_data.end_x >= in_data.start_x) begin
      cmd.delta_x = in_data.end_x - in_data.start_x;
    end else begin
      cmd.delta_x = in_data.start_x - in_data.end_x;
    end
    if (in_data.end_y >= in_data.start_y) begin
      cmd.delta_y = in_data.end_y - in_data.start_y;
    end else begin
      cmd.delta_y = in_data.start_y - in_data.end_y;
    end
    cmd.error_term = blr_pkg::ERR_W'(cmd.delta_x) - blr_pkg::ERR_W'(cmd.delta_y);
  end

endmodule

@@ rtl/blr_queue.sv @@
module blr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  blr_pkg::cmd_t       wr_data,
  input  logic                pop,
  output blr_pkg::cmd_t       rd_data,
  output blr_pkg::q_status_t  stat
);

  blr_pkg::cmd_t                   mem_r [blr_pkg::QUEUE_DEPTH];
  logic [blr_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [blr_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [blr_pkg::QCNT_W-1:0]      cnt_r;
  logic [blr_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [blr_pkg::QPTR_W-1:0]      rd_ptr_nxt;

  localparam logic [blr_pkg::QPTR_W-1:0] LastPtr = blr_pkg::QPTR_W'(blr_pkg::QUEUE_DEPTH - 1);
  localparam logic [blr_pkg::QCNT_W-1:0] FullCnt = blr_pkg::QCNT_W'(blr_pkg::QUEUE_DEPTH);

  // Status and head of queue
  always_comb begin
    stat.full  = (cnt_r == FullCnt);
    stat.empty = (cnt_r == '0);
    rd_data    = mem_r[rd_ptr_r];
    wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/blr_back.sv @@
module blr_back #(
  parameter int SCREEN_WIDTH  = blr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = blr_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  blr_pkg::cmd_t        head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output blr_pkg::out_item_t   out_data,
  output blr_pkg::back_stat_t  stat
);

  localparam int CW = blr_pkg::COORD_W;
  localparam int WB = $clog2(SCREEN_WIDTH + 1);
  localparam int PW = (CW + WB > blr_pkg::ADDR_W) ? CW + WB : blr_pkg::ADDR_W;
  localparam int SW = blr_pkg::ERR_W + 2;

  logic [CW-1:0]                cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [CW-1:0]                dx_r, dy_r;
  logic                         dir_x_neg_r, dir_y_neg_r;
  logic [blr_pkg::ERR_W-1:0]    err_r;
  logic [blr_pkg::COLOR_W-1:0]  color_r;
  logic                         active_r;
  logic                         out_valid_r;
  blr_pkg::out_item_t           out_r;

  logic                         out_free;
  logic                         emit;
  logic                         vis;
  logic                         fin;
  logic [PW-1:0]                prod;
  logic [blr_pkg::ADDR_W-1:0]   addr;
  logic signed [SW-1:0]         e2, dxs, dys, err_wide;
  logic                         step_x, step_y;
  logic [blr_pkg::ERR_W-1:0]    err_nxt;
  logic [CW-1:0]                cur_x_nxt, cur_y_nxt;

  // Pop control: loads and idle ticks never wait for the output register
  always_comb begin
    out_free = !out_valid_r || out_ready;
    pop      = q_valid && (head.is_load || !active_r || out_free);
    emit     = pop && !head.is_load && active_r;
  end

  // Current point, its address and the end-point test
  always_comb begin
    vis  = ({1'b0, cur_x_r} < (CW+1)'(SCREEN_WIDTH)) &&
           ({1'b0, cur_y_r} < (CW+1)'(SCREEN_HEIGHT));
    fin  = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
    prod = PW'(cur_y_r) * PW'(SCREEN_WIDTH);
    addr = vis ? (prod[blr_pkg::ADDR_W-1:0] + blr_pkg::ADDR_W'(cur_x_r)) : '0;
  end

  // One error step towards the end point
  always_comb begin
    e2       = {err_r[blr_pkg::ERR_W-1], err_r, 1'b0};
    dxs      = SW'(dx_r);
    dys      = SW'(dy_r);
    step_x   = e2 > -dys;
    step_y   = e2 < dxs;
    err_wide = {{2{err_r[blr_pkg::ERR_W-1]}}, err_r}
               - (step_x ? dys : '0) + (step_y ? dxs : '0);
    err_nxt  = err_wide[blr_pkg::ERR_W-1:0];
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (step_x) begin
      cur_x_nxt = dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (step_y) begin
      cur_y_nxt = dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  // Line state: load replaces, tick advances
  always_ff @(posedge clk) begin
    if (pop && head.is_load) begin
      cur_x_r     <= head.start_x;
      cur_y_r     <= head.start_y;
      tgt_x_r     <= head.end_x;
      tgt_y_r     <= head.end_y;
      dx_r        <= head.delta_x;
      dy_r        <= head.delta_y;
      dir_x_neg_r <= head.dir_x_neg;
      dir_y_neg_r <= head.dir_y_neg;
      err_r       <= head.error_term;
      color_r     <= head.color;
    end else if (emit && !fin) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  // Active flag and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && head.is_load) begin
        active_r <= 1'b1;
      end else if (emit && fin) begin
        active_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the point until the receiver takes it
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.point_x       <= cur_x_r;
      out_r.point_y       <= cur_y_r;
      out_r.pixel_address <= addr;
      out_r.pixel_color   <= color_r;
      out_r.visible       <= vis;
      out_r.last          <= fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.active    = active_r;
  assign stat.pop       = pop;
  assign stat.head_tick = !head.is_load;

endmodule
